// File: design/mbsb_pkg.sv
// Shared types and constants for the MSB-first bit stream buffer.
// No dependencies; imported by every other file of the block but mbsb_ram.
`timescale 1ns / 1ps
`default_nettype none

package mbsb_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 1024;
	localparam int unsigned MAX_CHUNK_BITS   = 64;
	localparam int unsigned DATA_W           = 64;
	localparam int unsigned CNT_W            = 7;
	localparam int unsigned POS_W            = 14;
	localparam int unsigned BYTE_W           = 8;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [CNT_W-1:0]  bit_count;
		logic [DATA_W-1:0] put_value;
	} req_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic              ok;
		logic              more_to_read;
		logic [POS_W-1:0]  write_position;
		logic [POS_W-1:0]  read_position;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic align;
		logic put_step;
		logic get_step;
		logic get_tail;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic put_go;
		logic get_go;
		logic last;
	} sts_t;

endpackage

`default_nettype wire

// File: design/mbsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mbsb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/mbsb_ctrl.sv
// Sequencer for the bit stream buffer: accepts items, steps the datapath
// and owns the result valid flag. Depends on mbsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbsb_ctrl import mbsb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ALIGN = 6'b000010,
		S_PUT   = 6'b000100,
		S_GET   = 6'b001000,
		S_TAIL  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   accept;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign accept    = req_valid && (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (sts.put_go) begin
						state_d = S_ALIGN;
					end else if (sts.get_go) begin
						state_d = S_GET;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_ALIGN: begin
				cmd.align = 1'b1;
				state_d   = S_PUT;
			end
			S_PUT: begin
				cmd.put_step = 1'b1;
				if (sts.last) begin
					state_d = S_DONE;
				end
			end
			S_GET: begin
				cmd.get_step = 1'b1;
				if (sts.last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				cmd.get_tail = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// hand over once the output register is free or being emptied
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/mbsb_dp.sv
// Datapath of the bit stream buffer: pointers, byte store, put merge
// register, get accumulator and result register. Depends on mbsb_pkg, mbsb_ram.
`timescale 1ns / 1ps
`default_nettype none

module mbsb_dp import mbsb_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_item_t req,
	input  wire cmd_t      cmd,
	output sts_t           sts,
	output rsp_item_t      rsp
);

	localparam int unsigned BITS  = BUFFER_BYTES * BYTE_W;
	localparam int unsigned PTR_W = $clog2(BITS + 1);
	localparam int unsigned SUM_W = PTR_W + 1;
	localparam int unsigned AW    = $clog2(BUFFER_BYTES);
	localparam int unsigned SH_W  = DATA_W + BYTE_W;

	logic [PTR_W-1:0]  wp_q, rp_q;
	logic              rd_pend_q;
	logic [CNT_W-1:0]  n_q;
	logic [2:0]        o_q;
	logic [2:0]        sh_q;
	logic [3:0]        left_q;
	logic [AW-1:0]     addr_q;
	logic [DATA_W-1:0] val_q;
	logic [SH_W-1:0]   shift_q;
	logic [DATA_W-1:0] acc_q;
	logic [BYTE_W-1:0] tail_q;
	logic [DATA_W-1:0] res_q;
	logic              ok_q;

	logic              cnt_ok, put_fits, get_fits, is_put, is_get, is_clear;
	logic [PTR_W-1:0]  base;
	logic [2:0]        o_in;
	logic [CNT_W-1:0]  span;
	logic [CNT_W-1:0]  total;
	logic [BYTE_W-1:0] rdata;
	logic [SH_W-1:0]   full;
	logic [DATA_W-1:0] mask;
	logic [BYTE_W-1:0] keep;

	assign is_put   = (req.op == OP_PUT);
	assign is_get   = (req.op == OP_GET);
	assign is_clear = (req.op == OP_CLEAR);
	assign cnt_ok   = (req.bit_count != '0) &&
	                  (req.bit_count <= CNT_W'(MAX_CHUNK_BITS));
	assign put_fits = (SUM_W'(wp_q) + SUM_W'(req.bit_count)) <= SUM_W'(BITS);
	assign get_fits = (SUM_W'(rp_q) + SUM_W'(req.bit_count)) <= SUM_W'(wp_q);

	assign sts.put_go = is_put && cnt_ok && put_fits;
	assign sts.get_go = is_get && cnt_ok && get_fits;
	assign sts.last   = (left_q == 4'd1);

	assign base  = is_put ? wp_q : rp_q;
	assign o_in  = base[2:0];
	assign total = CNT_W'(o_in) + req.bit_count;
	assign span  = total - CNT_W'(1);

	// bits of the partial byte that lie below the write pointer
	assign keep = ~(8'hFF >> o_q);
	assign full = {acc_q, rdata};
	assign mask = {DATA_W{1'b1}} >> (CNT_W'(DATA_W) - n_q);

	mbsb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.put_step),
		.waddr(addr_q),
		.wdata(shift_q[SH_W-1 -: BYTE_W]),
		.re   (cmd.get_step),
		.raddr(addr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.get_step;
			if (cmd.load && is_clear) begin
				wp_q <= '0;
				rp_q <= '0;
			end
			if (cmd.put_step && sts.last) begin
				wp_q <= PTR_W'(wp_q + PTR_W'(n_q));
			end
			if (cmd.get_tail) begin
				rp_q <= PTR_W'(rp_q + PTR_W'(n_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q   <= sts.put_go || sts.get_go || is_clear;
			res_q  <= '0;
			n_q    <= req.bit_count;
			o_q    <= o_in;
			sh_q   <= 3'(CNT_W'(0) - total);
			left_q <= 4'(span[CNT_W-1:3]) + 4'd1;
			addr_q <= AW'(base >> 3);
			// left-align the chunk; bits above the count fall off
			val_q  <= req.put_value << (CNT_W'(DATA_W) - req.bit_count);
		end
		if (cmd.align) begin
			shift_q <= ({val_q, 8'h00} >> o_q) | {tail_q & keep, {DATA_W{1'b0}}};
		end
		if (cmd.put_step) begin
			shift_q <= shift_q << BYTE_W;
			addr_q  <= addr_q + AW'(1);
			left_q  <= left_q - 4'd1;
			if (sts.last) begin
				tail_q <= shift_q[SH_W-1 -: BYTE_W];
			end
		end
		if (cmd.get_step) begin
			addr_q <= addr_q + AW'(1);
			left_q <= left_q - 4'd1;
			if (rd_pend_q) begin
				acc_q <= {acc_q[DATA_W-BYTE_W-1:0], rdata};
			end
		end
		if (cmd.get_tail) begin
			res_q <= DATA_W'(full >> sh_q) & mask;
		end
		if (cmd.emit) begin
			rsp.read_value     <= res_q;
			rsp.ok             <= ok_q;
			rsp.more_to_read   <= (rp_q < wp_q);
			rsp.write_position <= POS_W'(wp_q);
			rsp.read_position  <= POS_W'(rp_q);
		end
	end

endmodule

`default_nettype wire

// File: design/msb_first_bit_stream_buffer.sv
// MSB-first bit stream buffer, top level.
// Depends on mbsb_pkg, mbsb_ctrl, mbsb_dp (and mbsb_ram below it).
//
// Usage:
//   req channel (req_valid / req_stall / req): one item per put, get or clear.
//   rsp channel (rsp_valid / rsp_stall / rsp): exactly one result per item,
//   in order. An item is taken on a clock edge with valid high and stall low.
//   Items are handled one at a time; req_stall is high while one is in work.
//   A put or get spanning k bytes (k = 1..9) steps through the store byte by
//   byte; a clear, rejected item or unknown op goes straight to its result.
//   The byte-wide store sets the pace, one byte written or read a cycle.
//   The result appears on rsp from an output register once the work ends and
//   is held there, so the next item is accepted while it waits. If rsp_stall
//   is held, a second finished item waits inside until the register frees.
//   Reset clears both bit pointers and the handshake state; the byte store
//   is left as it is and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_stream_buffer import mbsb_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp
);

	cmd_t cmd;
	sts_t sts;

	mbsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbsb_dp #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for msb_first_bit_stream_buffer: directed table, then random put/get/clear
// traffic checked against a bit-level predictor of the stream store.
// Depends on mbsb_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_top;
	import mbsb_pkg::*;

	localparam int unsigned STORE_BITS     = BUFFER_BYTES_DEF * 8;
	localparam int          RANDOM_ITEMS   = 650;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          HOLDOFF_CYCLES = 400;
	localparam int          DRAIN_CYCLES   = 40;

	typedef struct packed {
		req_item_t item;
		logic      typed;
		rsp_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	// shadow of the block's store and pointers
	logic [7:0]  stream_bytes [BUFFER_BYTES_DEF];
	int unsigned wr_bit;
	int unsigned rd_bit;

	rsp_item_t pending_rsp [$];
	dir_row_t  dir_rows [$];
	int        fail_count;
	int        sent;
	int        quiet_cycles;
	bit        tx_burst;

	msb_first_bit_stream_buffer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// expected result of one item; advances the shadow state
	function automatic void advance_stream(input req_item_t it, output rsp_item_t r);
		int unsigned cnt;
		int unsigned i;
		bit          cnt_good;
		logic [63:0] acc;
		cnt = it.bit_count;
		cnt_good = (cnt >= 1) && (cnt <= MAX_CHUNK_BITS);
		acc = '0;
		r = '0;
		case (op_t'(it.op))
			OP_PUT: begin
				if (cnt_good && wr_bit + cnt <= STORE_BITS) begin
					for (i = cnt; i > 0; i--) begin
						stream_bytes[wr_bit >> 3][7 - (wr_bit & 7)] = it.put_value[i-1];
						wr_bit++;
					end
					r.ok = 1'b1;
				end
			end
			OP_GET: begin
				if (cnt_good && rd_bit + cnt <= wr_bit) begin
					for (i = 0; i < cnt; i++) begin
						acc = {acc[62:0], stream_bytes[rd_bit >> 3][7 - (rd_bit & 7)]};
						rd_bit++;
					end
					r.ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				wr_bit = 0;
				rd_bit = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.read_value     = acc;
		r.more_to_read   = (rd_bit < wr_bit);
		r.write_position = POS_W'(wr_bit);
		r.read_position  = POS_W'(rd_bit);
	endfunction

	function automatic void add_row(input op_t op, input int cnt, input logic [63:0] val,
			input bit typed, input logic [63:0] rv, input bit ok, input bit more,
			input int wp, input int rp);
		dir_row_t row;
		row.item.op              = op;
		row.item.bit_count       = CNT_W'(cnt);
		row.item.put_value       = val;
		row.typed                = typed;
		row.want.read_value      = rv;
		row.want.ok              = ok;
		row.want.more_to_read    = more;
		row.want.write_position  = POS_W'(wp);
		row.want.read_position   = POS_W'(rp);
		dir_rows.push_back(row);
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int tx_gap();
		if (tx_burst || $urandom_range(0, 99) < 55)
			return 0;
		return idle_len();
	endfunction

	function automatic logic [63:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '1;
		else if (r == 1)
			return '0;
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 64;
		else if (r < 25)
			return 1;
		return $urandom_range(1, 64);
	endfunction

	task automatic report_fail(input string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	// offer one item, hold it until taken, then record what should come back
	task automatic offer(input req_item_t it, input bit typed, input rsp_item_t want);
		int        gap;
		rsp_item_t pred;
		gap = tx_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		advance_stream(it, pred);
		pending_rsp.push_back(typed ? want : pred);
		sent++;
	endtask

	task automatic send_op(input op_t op, input int cnt, input logic [63:0] val);
		req_item_t it;
		it.op        = op;
		it.bit_count = CNT_W'(cnt);
		it.put_value = val;
		offer(it, 1'b0, '0);
	endtask

	// run the stream up to the end of the store, then past it; then read it dry or clear it
	task automatic fill_store(input bit drain_all);
		int c;
		int room;
		int avail;
		tx_burst = $urandom_range(0, 1);
		send_op(OP_CLEAR, 0, '0);
		send_op(OP_PUT, 3, rand_word());
		c = drain_all ? 64 : $urandom_range(32, 64);
		while (wr_bit + c <= STORE_BITS) begin
			send_op(OP_PUT, c, rand_word());
			c = drain_all ? 64 : $urandom_range(32, 64);
		end
		room = STORE_BITS - wr_bit;
		if (room < 64)
			send_op(OP_PUT, $urandom_range(room + 1, 64), rand_word());
		if (room > 0)
			send_op(OP_PUT, room, rand_word());
		send_op(OP_PUT, 1, rand_word());
		if (drain_all) begin
			while (rd_bit + 64 <= wr_bit)
				send_op(OP_GET, 64, rand_word());
			avail = wr_bit - rd_bit;
			if (avail > 0)
				send_op(OP_GET, avail, rand_word());
			send_op(OP_GET, 1, '0);
		end else begin
			repeat (4) send_op(OP_GET, $urandom_range(1, 64), '0);
			send_op(OP_CLEAR, $urandom_range(0, 127), rand_word());
		end
	endtask

	task automatic noise_item();
		int avail;
		avail = wr_bit - rd_bit;
		case ($urandom_range(0, 4))
			0: send_op(OP_NONE, $urandom_range(0, 127), rand_word());
			1: send_op(OP_PUT, $urandom_range(0, 1) ? 0 : $urandom_range(65, 127), rand_word());
			2: send_op(OP_GET, $urandom_range(0, 1) ? 0 : $urandom_range(65, 127), rand_word());
			3: begin
				if (avail < 64)
					send_op(OP_GET, $urandom_range(avail + 1, 64), rand_word());
				else
					send_op(OP_GET, 0, rand_word());
			end
			default: send_op(OP_CLEAR, $urandom_range(0, 127), rand_word());
		endcase
	endtask

	initial begin
		int fills;
		int r;
		int avail;
		req_valid <= 1'b0;
		req       <= '0;
		arst_n    <= 1'b0;
		fail_count = 0;
		sent = 0;
		wr_bit = 0;
		rd_bit = 0;
		tx_burst = 0;
		fills = 0;
		foreach (stream_bytes[i])
			stream_bytes[i] = '0;

		// underrun, bad counts, unknown op and clear from reset
		add_row(OP_GET,   1,  '0, 1, '0, 0, 0, 0, 0);
		add_row(OP_PUT,   0,  '1, 1, '0, 0, 0, 0, 0);
		add_row(OP_PUT,   65, '1, 1, '0, 0, 0, 0, 0);
		add_row(OP_NONE,  8,  '1, 1, '0, 0, 0, 0, 0);
		add_row(OP_CLEAR, 0,  '0, 1, '0, 1, 0, 0, 0);
		add_row(OP_PUT,   64, '1, 1, '0, 1, 1, 64, 0);
		// only the low bit counts, the ones above it are dropped
		add_row(OP_PUT,   1,  64'hFFFF_FFFF_FFFF_FFFE, 1, '0, 1, 1, 65, 0);
		add_row(OP_GET,   64, '0, 1, '1, 1, 1, 65, 64);
		add_row(OP_GET,   2,  '0, 1, '0, 0, 1, 65, 64);
		add_row(OP_GET,   1,  '0, 1, '0, 1, 0, 65, 65);
		add_row(OP_GET,   0,  '0, 1, '0, 0, 0, 65, 65);
		add_row(OP_GET,   127, '0, 1, '0, 0, 0, 65, 65);
		add_row(OP_PUT,   127, '1, 1, '0, 0, 0, 65, 65);
		// unaligned traffic, checked by prediction
		add_row(OP_PUT,   7,  64'h55, 0, '0, 0, 0, 0, 0);
		add_row(OP_PUT,   64, 64'h8000_0000_0000_0001, 0, '0, 0, 0, 0, 0);
		add_row(OP_PUT,   5,  64'hFFFF_FFFF_FFFF_FFF5, 0, '0, 0, 0, 0, 0);
		add_row(OP_GET,   3,  '0, 0, '0, 0, 0, 0, 0);
		add_row(OP_GET,   64, '0, 0, '0, 0, 0, 0, 0);
		add_row(OP_GET,   9,  '0, 0, '0, 0, 0, 0, 0);
		add_row(OP_GET,   1,  '0, 0, '0, 0, 0, 0, 0);
		add_row(OP_PUT,   64, '0, 0, '0, 0, 0, 0, 0);
		add_row(OP_GET,   64, '1, 0, '0, 0, 0, 0, 0);
		add_row(OP_CLEAR, 0,  '0, 1, '0, 1, 0, 0, 0);
		add_row(OP_NONE,  0,  '0, 1, '0, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		while (sent < dir_rows.size() + RANDOM_ITEMS) begin
			if (fills < 2 && sent >= 100 + 200 * fills) begin
				fill_store(fills == 1);
				fills++;
			end else begin
				tx_burst = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 65) begin
					repeat ($urandom_range(2, 10)) begin
						avail = wr_bit - rd_bit;
						if (avail > 0 && $urandom_range(0, 1))
							send_op(OP_GET, $urandom_range(1, avail < 64 ? avail : 64),
								rand_word());
						else if (wr_bit + 64 > STORE_BITS)
							send_op(OP_CLEAR, 0, '0);
						else
							send_op(OP_PUT, pick_count(), rand_word());
					end
				end else if (r < 75) begin
					send_op(OP_CLEAR, $urandom_range(0, 127), rand_word());
				end else begin
					noise_item();
				end
			end
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// result side: random stalls, quiet stretches, one long hold-off
	initial begin
		int seg_left;
		int hold_left;
		int rx_seen;
		int r;
		bit hold_done;
		seg_left = 0;
		hold_left = 0;
		rx_seen = 0;
		hold_done = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				rx_seen++;
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_done && rx_seen >= 60) begin
				hold_done = 1;
				hold_left = HOLDOFF_CYCLES;
				rsp_stall <= 1'b1;
			end else if (seg_left > 0) begin
				seg_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					rsp_stall <= 1'b0;
					seg_left = $urandom_range(50, 200);
				end else if (r < 50) begin
					rsp_stall <= 1'b1;
					seg_left = idle_len() - 1;
				end else begin
					rsp_stall <= 1'b0;
					seg_left = idle_len() - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_fail($sformatf("unexpected result: rv=%h ok=%b more=%b wp=%0d rp=%0d",
					rsp.read_value, rsp.ok, rsp.more_to_read,
					rsp.write_position, rsp.read_position));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.read_value !== want.read_value || rsp.ok !== want.ok ||
						rsp.more_to_read !== want.more_to_read ||
						rsp.write_position !== want.write_position ||
						rsp.read_position !== want.read_position)
					report_fail($sformatf(
						"mismatch: exp rv=%h ok=%b more=%b wp=%0d rp=%0d, got rv=%h ok=%b more=%b wp=%0d rp=%0d",
						want.read_value, want.ok, want.more_to_read,
						want.write_position, want.read_position,
						rsp.read_value, rsp.ok, rsp.more_to_read,
						rsp.write_position, rsp.read_position));
			end
		end
	end

	// ends the run if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// File: msb_first_bit_stream_buffer.f
design/mbsb_pkg.sv
design/mbsb_ram.sv
design/mbsb_ctrl.sv
design/mbsb_dp.sv
design/msb_first_bit_stream_buffer.sv
verif/tb_top.sv
